[rtl/spq_pkg.sv]
// Shared constants, codes and control structs for the sorted priority queue.
package spq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 5;
    localparam int STATUS_W      = 2;

    // Operation codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_POP_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic                load;
        logic                push;
        logic                pop;
        logic                capture;
        logic [STATUS_W-1:0] status;
    } t_spq_cmd;

    // Datapath to controller
    typedef struct packed {
        logic mode_pop;
        logic full;
        logic empty;
    } t_spq_stat;

endpackage

[rtl/spq_ctrl.sv]
// Sequencer for the sorted priority queue: input and output handshakes, operation issue.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  logic      i_stall,
    input  t_spq_stat i_stat,
    output t_spq_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_out_free;

    // Output slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_stall;

    // Decode state into commands
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_stall;
        o_cmd        = '0;
        o_cmd.status = STAT_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                    if (i_stat.mode_pop) begin
                        if (i_stat.empty) begin
                            o_cmd.status = STAT_POP_EMPTY;
                        end else begin
                            o_cmd.pop = 1'b1;
                        end
                    end else begin
                        if (i_stat.full) begin
                            o_cmd.status = STAT_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[rtl/spq_datapath.sv]
// Sorted entry chain, occupancy counter and result registers of the priority queue.
module spq_datapath
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_mode,
    input  logic signed [VALUE_W-1:0] i_push_value,
    input  t_spq_cmd                  i_cmd,
    output t_spq_stat                 o_stat,
    output logic signed [VALUE_W-1:0] o_head_value,
    output logic                      o_is_empty,
    output logic [ENTRY_COUNT_W-1:0]  o_entry_count,
    output logic [STATUS_W-1:0]       o_status
);

    logic                      r_mode;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] r_entries [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] n_entries [QUEUE_DEPTH];
    logic [COUNT_W-1:0]        r_count, n_count;
    logic [QUEUE_DEPTH-1:0]    w_keep;
    logic                      w_head_lt;
    logic signed [VALUE_W-1:0] w_next_head;

    logic signed [VALUE_W-1:0] r_head_value;
    logic                      r_is_empty;
    logic [COUNT_W-1:0]        r_out_count;
    logic [STATUS_W-1:0]       r_status;

    // New value goes in front when the queue is empty or the head is smaller
    assign w_head_lt = (r_count == '0) || (r_entries[0] < r_value);

    // Mark entries that stay ahead of the insert point; sorted order makes this a prefix
    always_comb begin
        w_keep[0] = !w_head_lt;
        for (int k = 1; k < QUEUE_DEPTH; k++) begin
            w_keep[k] = !w_head_lt && (COUNT_W'(k) < r_count) && (r_entries[k] > r_value);
        end
    end

    // Per-cell next value: keep, take the new value, or shift
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            n_entries[k] = r_entries[k];
        end
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + COUNT_W'(1);
            n_entries[0] = w_keep[0] ? r_entries[0] : r_value;
            for (int k = 1; k < QUEUE_DEPTH; k++) begin
                if (w_keep[k]) begin
                    n_entries[k] = r_entries[k];
                end else if (w_keep[k-1]) begin
                    n_entries[k] = r_value;
                end else begin
                    n_entries[k] = r_entries[k-1];
                end
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - COUNT_W'(1);
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                n_entries[k] = r_entries[k+1];
            end
        end
    end

    assign w_next_head = (n_count == '0) ? '0 : n_entries[0];

    // Latch the incoming beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_push_value;
        end
    end

    // Advance the entry chain
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            r_entries[k] <= n_entries[k];
        end
    end

    // Occupancy counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Capture the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_head_value <= w_next_head;
            r_is_empty   <= (n_count == '0);
            r_out_count  <= n_count;
            r_status     <= i_cmd.status;
        end
    end

    assign o_stat.mode_pop = (r_mode == MODE_POP);
    assign o_stat.full     = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign o_stat.empty    = (r_count == '0);

    assign o_head_value  = r_head_value;
    assign o_is_empty    = r_is_empty;
    assign o_entry_count = ENTRY_COUNT_W'(r_out_count);
    assign o_status      = r_status;

endmodule

[rtl/sorted_priority_queue.sv]
// Top level of the sorted max-first priority queue.
// An accepted beat is latched into the input registers; the execute state then
// updates the shared entry chain and captures the result. Accept and update alternate,
// so no new beat is taken meanwhile, and an unaccepted result holds the update.
// Reset: synchronous, active low; empties the queue and drops any pending result.
// Entry contents are not cleared, only the occupancy count.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_mode,
    input  logic signed [VALUE_W-1:0] i_push_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_head_value,
    output logic                      o_is_empty,
    output logic [ENTRY_COUNT_W-1:0]  o_entry_count,
    output logic [STATUS_W-1:0]       o_status
);

    t_spq_cmd  w_cmd;
    t_spq_stat w_stat;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    spq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_mode),
        .i_push_value  (i_push_value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_head_value  (o_head_value),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

endmodule

[rtl/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker
    import spq_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic signed [VALUE_W-1:0] o_head_value,
    input logic                      o_is_empty,
    input logic [ENTRY_COUNT_W-1:0]  o_entry_count,
    input logic [STATUS_W-1:0]       o_status
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_head_value) && $stable(o_status)
            && $stable(o_entry_count) && $stable(o_is_empty))
        else $error("result beat changed while stalled");

    // Empty queue reports zero head
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_head_value == '0)
        else $error("empty queue with nonzero head");

    // Rejected push means the queue was full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_FULL
            |-> o_entry_count == ENTRY_COUNT_W'(QUEUE_DEPTH) && !o_is_empty)
        else $error("push rejected on a queue that is not full");

    // Pop on empty leaves the queue empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_POP_EMPTY |-> o_is_empty && o_entry_count == '0)
        else $error("pop-on-empty flagged on a nonempty queue");

    // A beat accepted from an idle block yields a result once it is latched, executed and captured
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> ##1 o_valid)
        else $error("result beat missing after accepted input");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_head_value  (o_head_value),
    .o_is_empty    (o_is_empty),
    .o_entry_count (o_entry_count),
    .o_status      (o_status)
);

[bench/tb_sorted_priority_queue.sv]
// Self-checking testbench for the sorted max-first priority queue.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    // Expected result of one beat
    typedef struct {
        logic signed [VALUE_W-1:0] head;
        logic                      empty;
        logic [ENTRY_COUNT_W-1:0]  count;
        logic [STATUS_W-1:0]       status;
    } t_outcome;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_mode;
    logic signed [VALUE_W-1:0] i_push_value;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [VALUE_W-1:0] o_head_value;
    logic                      o_is_empty;
    logic [ENTRY_COUNT_W-1:0]  o_entry_count;
    logic [STATUS_W-1:0]       o_status;

    // Shadow copy of the queue contents
    logic signed [VALUE_W-1:0] shadow_entries [QUEUE_DEPTH];
    int                        shadow_count;

    t_outcome predicted_outcomes [$];
    bit       idle_enabled;
    int       error_count;
    int       beats_sent;
    int       full_rejects;
    int       empty_pops;
    int       results_checked;

    sorted_priority_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_head_value  (o_head_value),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    // Free-running clock, period 10
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Apply one beat to the shadow queue and queue its expected result
    task automatic apply_to_shadow(input logic mode, input logic signed [VALUE_W-1:0] value);
        t_outcome res;
        int       pos;
        int       k;
        res.status = STAT_OK;
        if (mode == MODE_POP) begin
            if (shadow_count == 0) begin
                res.status = STAT_POP_EMPTY;
                empty_pops++;
            end else begin
                for (k = 1; k < shadow_count; k++)
                    shadow_entries[k-1] = shadow_entries[k];
                shadow_count--;
            end
        end else begin
            if (shadow_count >= QUEUE_DEPTH) begin
                res.status = STAT_FULL;
                full_rejects++;
            end else begin
                // larger than head goes in front; otherwise after the last greater entry
                if (shadow_count == 0 || shadow_entries[0] < value) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < shadow_count && shadow_entries[pos] > value)
                        pos++;
                end
                for (k = shadow_count; k > pos; k--)
                    shadow_entries[k] = shadow_entries[k-1];
                shadow_entries[pos] = value;
                shadow_count++;
            end
        end
        res.head  = (shadow_count > 0) ? shadow_entries[0] : '0;
        res.empty = (shadow_count == 0);
        res.count = shadow_count[ENTRY_COUNT_W-1:0];
        predicted_outcomes.push_back(res);
    endtask

    // Drive one beat, optionally after a random gap, and hold it until accepted
    task automatic send_beat(input logic mode, input logic signed [VALUE_W-1:0] value);
        int gap;
        @(negedge i_clk);
        if (idle_enabled && $urandom_range(0, 99) < 11) begin
            gap = $urandom_range(1, 3);
            i_valid      <= 1'b0;
            i_mode       <= 1'($urandom_range(0, 1));
            i_push_value <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_push_value <= value;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        apply_to_shadow(mode, value);
        beats_sent++;
    endtask

    // Lower valid and wait for every outstanding result
    task automatic wait_all_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (predicted_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Mix of extremes, duplicates and fully random values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: pick_value = 32'sh7FFF_FFFF;
            1: pick_value = 32'sh8000_0000;
            2, 3: pick_value = $signed($urandom_range(0, 8)) - 32'sd4;
            default: pick_value = $urandom;
        endcase
    endfunction

    // Pop on empty, push into empty, drain back to empty
    task automatic test_empty_edges();
        send_beat(MODE_POP, 32'sh0000_0000);
        send_beat(MODE_PUSH, 32'sh8000_0000);
        send_beat(MODE_POP, 32'shFFFF_FFFF);
    endtask

    // Fill with extremes and equal values, then push twice on full
    task automatic test_fill_and_overflow();
        int n;
        send_beat(MODE_PUSH, 32'sh7FFF_FFFF);
        send_beat(MODE_PUSH, 32'sh7FFF_FFFF);
        send_beat(MODE_PUSH, 32'sh0000_0000);
        send_beat(MODE_PUSH, 32'sh0000_0000);
        send_beat(MODE_PUSH, 32'shFFFF_FFFF);
        send_beat(MODE_PUSH, 32'sh8000_0000);
        for (n = 0; n < QUEUE_DEPTH - 6; n++)
            send_beat(MODE_PUSH, $signed($urandom_range(0, 6)) - 32'sd3);
        send_beat(MODE_PUSH, 32'sh0000_0005);
        send_beat(MODE_PUSH, 32'sh7FFF_FFFF);
    endtask

    // Phases that lean toward filling or draining so both limits are hit often
    task automatic test_random_phases(input int total);
        int  sent;
        int  span;
        int  push_pct;
        bit  fill_phase;
        fill_phase = 1'b0;
        sent = 0;
        while (sent < total) begin
            span = $urandom_range(10, 40);
            push_pct = fill_phase ? 75 : 25;
            repeat (span) begin
                if ($urandom_range(0, 99) < push_pct)
                    send_beat(MODE_PUSH, pick_value());
                else
                    send_beat(MODE_POP, $urandom);
                sent++;
            end
            fill_phase = !fill_phase;
        end
    endtask

    // Back-to-back beats with no idling on either side
    task automatic test_steady_stream(input int total);
        idle_enabled = 1'b0;
        repeat (total) begin
            if ($urandom_range(0, 1))
                send_beat(MODE_PUSH, pick_value());
            else
                send_beat(MODE_POP, $urandom);
        end
        idle_enabled = 1'b1;
    endtask

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_stall <= idle_enabled && ($urandom_range(0, 99) < 11);
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_outcomes.size() == 0) begin
                $error("result with no prediction pending: head=%0d", o_head_value);
                error_count++;
            end else begin
                want = predicted_outcomes.pop_front();
                results_checked++;
                if (o_head_value !== want.head) begin
                    $error("head_value expected %0d actual %0d", want.head, o_head_value);
                    error_count++;
                end
                if (o_is_empty !== want.empty) begin
                    $error("is_empty expected %0d actual %0d", want.empty, o_is_empty);
                    error_count++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count expected %0d actual %0d", want.count, o_entry_count);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_mode       = MODE_PUSH;
        i_push_value = '0;
        idle_enabled = 1'b1;
        shadow_count = 0;
        error_count  = 0;
        beats_sent   = 0;
        full_rejects = 0;
        empty_pops   = 0;
        results_checked = 0;
        for (int k = 0; k < QUEUE_DEPTH; k++)
            shadow_entries[k] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_edges();
        test_fill_and_overflow();
        // hold the sender until the queue has answered everything
        wait_all_results();
        test_random_phases(380);
        wait_all_results();
        test_steady_stream(170);
        wait_all_results();
        repeat (10) @(posedge i_clk);

        $display("covered %0d beats with %0d full rejects and %0d empty pops",
                 beats_sent, full_rejects, empty_pops);
        $display("checked %0d results, %0d mismatches", results_checked, error_count);
        if (error_count == 0 && predicted_outcomes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
